[hdl/mwrs_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, state codes and types of the modular weighted range sum block.
// Used by modular_weighted_range_sum, mwrs_mulmod and mwrs_port_checks; depends on nothing.
package mwrs_pkg;
	localparam int unsigned DEF_TABLE_DEPTH = 1024;
	localparam int unsigned VW = 30;
	localparam logic [VW-1:0] PRIME = 30'd1000000007;

	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_BAD_RANGE = 2'd1;
	localparam logic [1:0] STAT_NO_INV = 2'd2;
	localparam logic [1:0] STAT_FULL = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE, S_RED, S_TERM, S_POWK, S_RD_R, S_RD_L, S_SQ, S_MK, S_FIN, S_OUT
	} mwrs_state_t;

	typedef struct packed {
		logic go;
		logic [VW-1:0] a;
		logic [VW-1:0] b;
	} mwrs_mul_req_t;
endpackage

[hdl/modular_weighted_range_sum.sv]
`timescale 1ns / 1ps
// An append holds the input while up to four subtractions reduce the element,
// then two bit-serial products run; it gives no word unless the table is full.
// A query gives its word after N = 31 + popcount(p - l) products
// of one shared multiplier for k^(p - l) and the final product; N is at most 53.
// One word is in work at a time; an error answers without any product.
// arst_n clears the control state, sets the base and running power to one.
module modular_weighted_range_sum #(
	parameter int unsigned TABLE_DEPTH = mwrs_pkg::DEF_TABLE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [mwrs_pkg::VW-1:0] cfg_wdata,   // base_k
	input logic s_tvalid,
	output logic s_tready,
	input logic [55:0] s_tdata,     // element_value[31:0], left_index[41:32], right_index[51:42]
	input logic s_tuser,            // opcode
	output logic m_tvalid,
	input logic m_tready,
	output logic [31:0] m_tdata     // range_result[29:0], status[31:30]
);
	import mwrs_pkg::*;

	localparam int unsigned AW = $clog2(TABLE_DEPTH);
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

	mwrs_state_t state_q, state_d;
	mwrs_mul_req_t mreq;
	logic mul_done;
	logic [VW-1:0] prod;

	logic [VW-1:0] k_q, rp_q, last_q, hi_q, diff_q, exp_q, res_q;
	logic [CW-1:0] cnt_q;
	logic [31:0] v_q;
	logic [9:0] l_q;
	logic [1:0] stat_q;
	logic [4:0] bit_q;
	logic m_tvalid_q;
	logic [31:0] m_tdata_q;

	logic in_acc, full, bad, kzero, v_ge, out_free;
	logic [9:0] in_l, in_r;
	logic [VW:0] sum, dsum;
	logic [VW-1:0] pref, lower, diff;
	logic ram_we;
	logic [AW-1:0] ram_raddr;
	logic [VW-1:0] ram_rdata;

	assign in_l = s_tdata[41:32];
	assign in_r = s_tdata[51:42];
	assign s_tready = (state_q == S_IDLE);
	assign in_acc = s_tvalid && s_tready;
	assign full = (cnt_q == CW'(TABLE_DEPTH));
	assign bad = (in_l > in_r) || (32'(in_r) >= 32'(cnt_q));
	assign kzero = (k_q == '0);
	assign v_ge = (v_q >= {2'b00, PRIME});
	assign out_free = !m_tvalid_q || m_tready;

	assign sum = {1'b0, last_q} + {1'b0, prod};
	assign pref = (sum >= {1'b0, PRIME}) ? VW'(sum - {1'b0, PRIME}) : sum[VW-1:0];
	assign lower = (l_q == 10'd0) ? '0 : ram_rdata;
	assign dsum = {1'b0, hi_q} + {1'b0, PRIME} - {1'b0, lower};
	assign diff = (hi_q >= lower) ? hi_q - lower : dsum[VW-1:0];

	always_comb begin
		state_d = state_q;
		mreq = '0;
		ram_we = 1'b0;
		ram_raddr = AW'(in_r);
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					if (s_tuser == OP_APPEND) begin
						state_d = full ? S_OUT : S_RED;
					end else if (bad || kzero) begin
						state_d = S_OUT;
					end else begin
						state_d = S_RD_R;
					end
				end
			end
			S_RED: begin
				if (!v_ge) begin
					mreq = '{go: 1'b1, a: v_q[VW-1:0], b: rp_q};
					state_d = S_TERM;
				end
			end
			S_TERM: begin
				if (mul_done) begin
					ram_we = 1'b1;
					mreq = '{go: 1'b1, a: rp_q, b: k_q};
					state_d = S_POWK;
				end
			end
			S_POWK: begin
				if (mul_done) begin
					state_d = S_IDLE;
				end
			end
			S_RD_R: begin
				ram_raddr = AW'(l_q - 10'd1);
				state_d = S_RD_L;
			end
			S_RD_L: begin
				mreq = '{go: 1'b1, a: VW'(1), b: VW'(1)};
				state_d = S_SQ;
			end
			S_SQ: begin
				if (mul_done) begin
					if (exp_q[bit_q]) begin
						mreq = '{go: 1'b1, a: prod, b: k_q};
						state_d = S_MK;
					end else if (bit_q == 5'd0) begin
						mreq = '{go: 1'b1, a: prod, b: diff_q};
						state_d = S_FIN;
					end else begin
						mreq = '{go: 1'b1, a: prod, b: prod};
					end
				end
			end
			S_MK: begin
				if (mul_done) begin
					if (bit_q == 5'd0) begin
						mreq = '{go: 1'b1, a: prod, b: diff_q};
						state_d = S_FIN;
					end else begin
						mreq = '{go: 1'b1, a: prod, b: prod};
						state_d = S_SQ;
					end
				end
			end
			S_FIN: begin
				if (mul_done) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q <= VW'(1);
			rp_q <= VW'(1);
			last_q <= '0;
			cnt_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				k_q <= (cfg_wdata >= PRIME) ? cfg_wdata - PRIME : cfg_wdata;
			end
			if (state_q == S_TERM && mul_done) begin
				last_q <= pref;
			end
			if (state_q == S_POWK && mul_done) begin
				rp_q <= prod;
				cnt_q <= cnt_q + CW'(1);
			end
			if (state_q == S_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				v_q <= s_tdata[31:0];
				l_q <= in_l;
				exp_q <= PRIME - VW'(in_l);
				bit_q <= 5'(VW - 1);
				res_q <= '0;
				if (s_tuser == OP_APPEND) begin
					stat_q <= STAT_FULL;
				end else if (bad) begin
					stat_q <= STAT_BAD_RANGE;
				end else begin
					stat_q <= STAT_NO_INV;
				end
			end
			S_RED: begin
				if (v_ge) begin
					v_q <= v_q - {2'b00, PRIME};
				end
			end
			S_RD_R: hi_q <= ram_rdata;
			S_RD_L: diff_q <= diff;
			S_SQ: begin
				if (mul_done && !exp_q[bit_q] && bit_q != 5'd0) begin
					bit_q <= bit_q - 5'd1;
				end
			end
			S_MK: begin
				if (mul_done && bit_q != 5'd0) begin
					bit_q <= bit_q - 5'd1;
				end
			end
			S_FIN: begin
				if (mul_done) begin
					res_q <= prod;
					stat_q <= STAT_OK;
				end
			end
			S_OUT: begin
				if (out_free) begin
					m_tdata_q <= {stat_q, res_q};
				end
			end
			default: ;
		endcase
	end

	mwrs_mulmod u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.req(mreq),
		.done(mul_done),
		.prod(prod)
	);

	mwrs_ram #(
		.WIDTH(VW),
		.DEPTH(TABLE_DEPTH)
	) u_prefix (
		.clk(clk),
		.we(ram_we),
		.waddr(cnt_q[AW-1:0]),
		.wdata(pref),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
endmodule

[hdl/mwrs_ram.sv]
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module mwrs_ram #(
	parameter int unsigned WIDTH = 30,
	parameter int unsigned DEPTH = 1024
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[hdl/mwrs_mulmod.sv]
`timescale 1ns / 1ps
// Bit-serial modular multiplier, one bit of the first operand per cycle, MSB first.
// Depends on mwrs_pkg.
module mwrs_mulmod (
	input logic clk,
	input logic arst_n,
	input mwrs_pkg::mwrs_mul_req_t req,
	output logic done,
	output logic [mwrs_pkg::VW-1:0] prod
);
	import mwrs_pkg::*;

	logic [VW-1:0] a_q, b_q, acc_q;
	logic [4:0] cnt_q;
	logic busy_q, done_q;
	logic [VW+1:0] t0, t1, t2;

	always_comb begin
		t0 = {1'b0, acc_q, 1'b0} + (a_q[VW-1] ? {2'b00, b_q} : '0);
		t1 = (t0 >= {2'b00, PRIME}) ? t0 - {2'b00, PRIME} : t0;
		t2 = (t1 >= {2'b00, PRIME}) ? t1 - {2'b00, PRIME} : t1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && !req.go && (cnt_q == 5'd0);
			if (req.go) begin
				busy_q <= 1'b1;
				cnt_q <= 5'(VW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			a_q <= req.a;
			b_q <= req.b;
			acc_q <= '0;
		end else if (busy_q) begin
			a_q <= {a_q[VW-2:0], 1'b0};
			acc_q <= t2[VW-1:0];
		end
	end

	assign done = done_q;
	assign prod = acc_q;
endmodule

[hdl/mwrs_checker.sv]
`timescale 1ns / 1ps
// Port-level checks of the modular weighted range sum block, bound to its top level.
// Depends on modular_weighted_range_sum and mwrs_pkg.
module mwrs_port_checks (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [31:0] m_tdata
);
	import mwrs_pkg::*;

	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("Input taken while a word was still in work.");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("Stalled output word changed.");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[31:30] != STAT_OK |-> m_tdata[29:0] == 30'd0)
		else $error("Error word carries a nonzero sum.");

	a_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[31:30] == STAT_OK |-> m_tdata[29:0] < PRIME)
		else $error("Result is not reduced modulo the prime.");
endmodule

bind modular_weighted_range_sum mwrs_port_checks u_mwrs_port_checks (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);
